// ----- rtl/fpd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and fixed field widths for the fixed-point divider.
// No dependencies.
package fpd_pkg;

	// Stream field widths
	localparam int DIVIDEND_W = 16;
	localparam int DIVISOR_W  = 8;
	localparam int QINT_W     = 16;
	localparam int QFRAC_W    = 8;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 32;

	// Control that rides along with each item through the cell chain
	typedef struct packed {
		logic valid;
		logic dbz;   // divisor was zero
		logic rz;    // integer remainder was zero (meaningful past the integer cells)
	} ctl_t;

endpackage

// ----- rtl/fpd_cell.sv -----
`timescale 1ns / 1ps
// One restoring division step with its stage register.
// Depends on fpd_pkg.
module fpd_cell
	import fpd_pkg::*;
#(
	parameter int DVS_W  = 8,
	parameter int WORD_W = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  ctl_t              ctl_in,
	input  logic [DVS_W-1:0]  rem_in,
	input  logic [WORD_W-1:0] word_in,
	input  logic [DVS_W-1:0]  dvs_in,
	output ctl_t              ctl_out,
	output logic [DVS_W-1:0]  rem_out,
	output logic [WORD_W-1:0] word_out,
	output logic [DVS_W-1:0]  dvs_out
);

	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              ge;
	logic [DVS_W-1:0]  rem_next;
	logic [WORD_W-1:0] word_next;

	ctl_t              ctl_q;
	logic [DVS_W-1:0]  rem_q;
	logic [WORD_W-1:0] word_q;
	logic [DVS_W-1:0]  dvs_q;

	// shift next dividend bit into the partial remainder, try the subtract
	assign trial     = {rem_in, word_in[WORD_W-1]};
	assign diff      = trial - {1'b0, dvs_in};
	assign ge        = (trial >= {1'b0, dvs_in});
	// result is below the divisor, so it fits in DVS_W bits
	assign rem_next  = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
	assign word_next = {word_in[WORD_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= rem_next;
			word_q <= word_next;
			dvs_q  <= dvs_in;
		end
	end

	assign ctl_out  = ctl_q;
	assign rem_out  = rem_q;
	assign word_out = word_q;
	assign dvs_out  = dvs_q;

endmodule

// ----- rtl/fixed_point_divider_16by8_unit.sv -----
`timescale 1ns / 1ps
// Top level of the pipelined fixed-point divider: a chain of restoring-step cells.
// Depends on fpd_pkg and fpd_cell.
//
// Usage
//  - Input channel (s_*): one item = dividend (s_tdata[15:0]) and divisor
//    (s_tdata[23:16]), both unsigned.
//  - Output channel (m_*): quotient = floor(dividend * 2^FRACTION_BITS / divisor),
//    integer part in m_tdata[15:0], fraction in m_tdata[23:16], remainder-zero
//    flag in m_tdata[24]; m_tuser flags a zero divisor (quotient all ones).
//  - Chain: one cell per quotient bit; each cell does one compare-and-subtract
//    and registers it.
//  - Throughput: one item per cycle unless the output stalls. The chain holds
//    up to DIVIDEND_BITS + FRACTION_BITS items in flight.
//  - Stall: the whole chain advances together. When the last cell holds an item
//    that the receiver does not take, every cell holds and s_tready drops;
//    while the output is empty or being taken the chain moves one cell per
//    cycle and gaps between items travel along with it.
//  - Reset: arst_n clears all cell valid bits at once; the chain comes up empty
//    and ready. Data registers are not reset.
//  - Input bits above DIVIDEND_BITS / DIVISOR_BITS are ignored; the integer
//    quotient is presented truncated or zero-extended to 16 bits.
module fixed_point_divider_16by8_unit
	import fpd_pkg::*;
#(
	parameter int DIVIDEND_BITS = 16,
	parameter int DIVISOR_BITS  = 8,
	parameter int FRACTION_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// [15:0] dividend, [23:16] divisor
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [15:0] quotient_integer, [23:16] quotient_fraction, [24] remainder_zero,
	// [31:25] zero
	output logic [M_TDATA_W-1:0] m_tdata,
	// [0] divide_by_zero
	output logic                 m_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready
);

	// one cell per quotient bit, integer bits first
	localparam int STEPS = DIVIDEND_BITS + FRACTION_BITS;
	localparam int PAD_W = M_TDATA_W - QINT_W - QFRAC_W - 1;

	logic                     en;
	logic [DIVIDEND_BITS-1:0] in_dvd;
	logic [DIVISOR_BITS-1:0]  in_dvs;
	logic [STEPS-1:0]         in_word;
	ctl_t                     in_ctl;

	ctl_t                     stage_ctl  [STEPS];
	logic [DIVISOR_BITS-1:0]  stage_rem  [STEPS];
	logic [STEPS-1:0]         stage_word [STEPS];
	logic [DIVISOR_BITS-1:0]  stage_dvs  [STEPS];

	logic                     last_rz;
	logic [QINT_W-1:0]        q_int;
	logic [QFRAC_W-1:0]       q_frac;
	logic                     rem_zero;

	// Global advance: the last cell is the output register.
	assign en       = !stage_ctl[STEPS-1].valid || m_tready;
	assign s_tready = en;

	// Mask to parameter widths; dividend sits above FRACTION_BITS zero bits
	// so the fraction steps just keep shifting zeros into the remainder.
	assign in_dvd  = DIVIDEND_BITS'(s_tdata[DIVIDEND_W-1:0]);
	assign in_dvs  = DIVISOR_BITS'(s_tdata[DIVIDEND_W +: DIVISOR_W]);
	assign in_word = STEPS'(in_dvd) << FRACTION_BITS;

	always_comb begin
		in_ctl       = '0;
		in_ctl.valid = s_tvalid;
		in_ctl.dbz   = (in_dvs == '0);
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		ctl_t                    c_ctl;
		logic [DIVISOR_BITS-1:0] c_rem;
		logic [STEPS-1:0]        c_word;
		logic [DIVISOR_BITS-1:0] c_dvs;

		if (i == 0) begin : g_first
			assign c_ctl  = in_ctl;
			assign c_rem  = '0;
			assign c_word = in_word;
			assign c_dvs  = in_dvs;
		end else if (i == DIVIDEND_BITS) begin : g_boundary
			// integer part done: snapshot whether the remainder is zero
			always_comb begin
				c_ctl    = stage_ctl[i-1];
				c_ctl.rz = (stage_rem[i-1] == '0);
			end
			assign c_rem  = stage_rem[i-1];
			assign c_word = stage_word[i-1];
			assign c_dvs  = stage_dvs[i-1];
		end else begin : g_mid
			assign c_ctl  = stage_ctl[i-1];
			assign c_rem  = stage_rem[i-1];
			assign c_word = stage_word[i-1];
			assign c_dvs  = stage_dvs[i-1];
		end

		fpd_cell #(
			.DVS_W  (DIVISOR_BITS),
			.WORD_W (STEPS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctl_in   (c_ctl),
			.rem_in   (c_rem),
			.word_in  (c_word),
			.dvs_in   (c_dvs),
			.ctl_out  (stage_ctl[i]),
			.rem_out  (stage_rem[i]),
			.word_out (stage_word[i]),
			.dvs_out  (stage_dvs[i])
		);
	end

	// Result fields from the last cell
	if (FRACTION_BITS == 0) begin : g_nofrac
		assign last_rz = (stage_rem[STEPS-1] == '0);
		assign q_frac  = '0;
	end else begin : g_frac
		assign last_rz = stage_ctl[STEPS-1].rz;
		assign q_frac  = QFRAC_W'(stage_word[STEPS-1][FRACTION_BITS-1:0]);
	end

	// a zero divisor makes every trial subtract succeed: quotient comes out all ones
	assign q_int    = QINT_W'(stage_word[STEPS-1][STEPS-1:FRACTION_BITS]);
	assign rem_zero = last_rz && !stage_ctl[STEPS-1].dbz;

	assign m_tdata  = {{PAD_W{1'b0}}, rem_zero, q_frac, q_int};
	assign m_tuser  = stage_ctl[STEPS-1].dbz;
	assign m_tvalid = stage_ctl[STEPS-1].valid;

	// zero divisor never reports a clean remainder
	a_dbz_no_rz: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> !m_tdata[QINT_W + QFRAC_W])
		else $error("remainder_zero set on divide by zero");

	// zero divisor yields an all-ones fraction
	a_dbz_frac: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |->
			(q_frac == QFRAC_W'((64'd1 << FRACTION_BITS) - 64'd1)))
		else $error("fraction not all ones on divide by zero");

	// exact integer division leaves nothing for the fraction steps
	a_rz_frac: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser && rem_zero) |-> (q_frac == '0))
		else $error("nonzero fraction with zero remainder");

	// an empty output register never blocks the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output empty");

endmodule

// ----- sim/fpd_quotient_checker.sv -----
`timescale 1ns / 1ps
// Quotient checker for the fixed-point divider: watches both stream channels,
// predicts each quotient and compares it in order. Depends on fpd_pkg.
module fpd_quotient_checker
	import fpd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 m_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	output int                   mismatches,
	output int                   pending,
	output int                   checked
);

	typedef struct packed {
		logic [QINT_W-1:0]  whole;
		logic [QFRAC_W-1:0] frac;
		logic               exact;
		logic               div_zero;
	} quotient_t;

	quotient_t quotients_due[$];

	// restoring division, MSB first, then fraction bits on the remainder
	function automatic quotient_t divide_fixed(input logic [DIVIDEND_W-1:0] dvd,
			input logic [DIVISOR_W-1:0] dvs);
		quotient_t q;
		logic [DIVISOR_W:0] part;
		q = '0;
		part = '0;
		if (dvs == '0) begin
			q.whole = '1;
			q.frac = '1;
			q.div_zero = 1'b1;
			return q;
		end
		for (int b = DIVIDEND_W - 1; b >= 0; b--) begin
			part = {part[DIVISOR_W-1:0], dvd[b]};
			if (part >= {1'b0, dvs}) begin
				part = part - {1'b0, dvs};
				q.whole[b] = 1'b1;
			end
		end
		q.exact = (part == '0);
		for (int b = QFRAC_W - 1; b >= 0; b--) begin
			part = {part[DIVISOR_W-1:0], 1'b0};
			if (part >= {1'b0, dvs}) begin
				part = part - {1'b0, dvs};
				q.frac[b] = 1'b1;
			end
		end
		return q;
	endfunction

	always @(posedge clk) begin : compare
		quotient_t want;
		quotient_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				quotients_due.push_back(divide_fixed(s_tdata[DIVIDEND_W-1:0],
					s_tdata[DIVIDEND_W+DIVISOR_W-1:DIVIDEND_W]));
			if (m_tvalid && m_tready) begin
				got.whole = m_tdata[QINT_W-1:0];
				got.frac = m_tdata[QINT_W+QFRAC_W-1:QINT_W];
				got.exact = m_tdata[QINT_W+QFRAC_W];
				got.div_zero = m_tuser;
				checked++;
				if (quotients_due.size() == 0) begin
					$error("unexpected result item: tdata %h tuser %b", m_tdata, m_tuser);
					mismatches++;
				end else begin
					want = quotients_due.pop_front();
					if (got.whole !== want.whole) begin
						$error("quotient_integer: expected %h, got %h", want.whole, got.whole);
						mismatches++;
					end
					if (got.frac !== want.frac) begin
						$error("quotient_fraction: expected %h, got %h", want.frac, got.frac);
						mismatches++;
					end
					if (got.exact !== want.exact) begin
						$error("remainder_zero: expected %b, got %b", want.exact, got.exact);
						mismatches++;
					end
					if (got.div_zero !== want.div_zero) begin
						$error("divide_by_zero: expected %b, got %b",
							want.div_zero, got.div_zero);
						mismatches++;
					end
				end
			end
			pending = quotients_due.size();
		end
	end

endmodule

// ----- sim/tb_fixed_point_divider_16by8_unit.sv -----
`timescale 1ns / 1ps
// Testbench top for the fixed-point divider: clock, reset, operand stimulus and verdict.
// Depends on fpd_pkg, fixed_point_divider_16by8_unit and fpd_quotient_checker.
module tb_fixed_point_divider_16by8_unit;
	import fpd_pkg::*;

	localparam int LATENCY      = 24;      // one cell per quotient bit
	localparam int LIMIT_CYCLES = 300000;  // several times the slowest correct run
	localparam int PHASE_ITEMS  = 190;     // random items per handshake phase
	localparam int BURST_CYCLES = 120;     // long output hold, well past the chain depth

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;

	int mismatches;
	int pending;
	int checked;

	// handshake pressure, in percent of cycles
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit burst_req = 1'b0;

	int items_sent = 0;
	int zero_divisors = 0;

	fixed_point_divider_16by8_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	fpd_quotient_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tdata    (s_tdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Offer one operand pair, with random idle cycles ahead of it, and hold it until taken.
	// tvalid stays high between back-to-back items.
	task automatic offer_operands(input logic [DIVIDEND_W-1:0] dvd,
			input logic [DIVISOR_W-1:0] dvs);
		while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {dvs, dvd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		if (dvs == '0)
			zero_divisors++;
	endtask

	// Random operands: zero and tiny divisors get extra weight, and some dividends
	// are built as exact multiples so the remainder-zero flag sees both values.
	task automatic random_item();
		logic [DIVIDEND_W-1:0] dvd;
		logic [DIVISOR_W-1:0] dvs;
		int pick;
		pick = int'($urandom_range(9, 0));
		dvd = DIVIDEND_W'($urandom());
		case (pick)
			0: dvs = '0;
			1, 2: dvs = DIVISOR_W'($urandom_range(3, 1));
			3: dvs = '1;
			default: dvs = DIVISOR_W'($urandom_range(255, 1));
		endcase
		if (pick >= 7 && dvs != '0)
			dvd = DIVIDEND_W'(dvs * $urandom_range(65535 / dvs, 0));
		offer_operands(dvd, dvs);
	endtask

	// Output side: random stalls, plus a long hold when the stimulus asks for one.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (burst_req) begin
				burst_req = 1'b0;
				hold_left = BURST_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: a run that stalls or loses items ends here.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("fixed_point_divider_16by8_unit regression: fail");
		$finish;
	end

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero divisor at both dividend extremes, divide by one, the largest
		// divisor, alternating bit patterns, exact and inexact splits
		offer_operands(16'h0000, 8'h00);
		offer_operands(16'hffff, 8'h00);
		offer_operands(16'h1234, 8'h00);
		offer_operands(16'h0000, 8'h01);
		offer_operands(16'hffff, 8'h01);
		offer_operands(16'h0001, 8'h01);
		offer_operands(16'hffff, 8'hff);
		offer_operands(16'hfffe, 8'hff);
		offer_operands(16'h0001, 8'hff);
		offer_operands(16'h0000, 8'hff);
		offer_operands(16'h00ff, 8'hff);
		offer_operands(16'hffff, 8'h02);
		offer_operands(16'h8000, 8'h80);
		offer_operands(16'h0100, 8'h10);
		offer_operands(16'h3039, 8'h07);
		offer_operands(16'h0064, 8'h03);
		offer_operands(16'haaaa, 8'haa);
		offer_operands(16'h5555, 8'h55);
		offer_operands(16'h5555, 8'haa);
		offer_operands(16'haaaa, 8'h55);
		offer_operands(16'h0001, 8'h03);
		offer_operands(16'h007f, 8'h80);

		// random phases: free flow, sparse sender, slow receiver, both mildly idle
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (PHASE_ITEMS) random_item();
		send_idle_pct = 81;
		repeat (PHASE_ITEMS) random_item();
		send_idle_pct = 0;
		recv_stall_pct = 81;
		repeat (PHASE_ITEMS) random_item();
		send_idle_pct = 23;
		recv_stall_pct = 23;
		repeat (PHASE_ITEMS) random_item();

		// back-pressure: hold the output off while items keep coming, so the chain
		// fills and s_tready drops
		send_idle_pct = 0;
		recv_stall_pct = 0;
		burst_req = 1'b1;
		repeat (PHASE_ITEMS) random_item();

		s_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);

		$display("%0d operand pairs (%0d with a zero divisor) over five handshake phases,",
			items_sent, zero_divisors);
		$display("including one long output hold; %0d quotients compared", checked);
		if (mismatches == 0 && pending == 0)
			$display("fixed_point_divider_16by8_unit regression: pass");
		else
			$display("fixed_point_divider_16by8_unit regression: fail");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/fpd_pkg.sv
rtl/fpd_cell.sv
rtl/fixed_point_divider_16by8_unit.sv
sim/fpd_quotient_checker.sv
sim/tb_fixed_point_divider_16by8_unit.sv
